>>> hdl/nes_pkg.sv
package nes_pkg;

  // Default note table depth
  localparam int NES_TABLE_DEPTH = 256;

  // Commands carried by the input channel
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ATTACK_LEVEL      = 3'd0;
  localparam logic [2:0] REG_ATTACK_RATE       = 3'd1;
  localparam logic [2:0] REG_HOLD_LEVEL        = 3'd2;
  localparam logic [2:0] REG_HOLD_RATE         = 3'd3;
  localparam logic [2:0] REG_DECAY_RATE        = 3'd4;
  localparam logic [2:0] REG_LENGTH_MULTIPLIER = 3'd5;
  localparam logic [2:0] REG_HOLD_FIXED_ENABLE = 3'd6;
  localparam logic [2:0] REG_HOLD_FIXED_COUNT  = 3'd7;

  // Envelope phase codes
  localparam logic [1:0] PH_ATTACK = 2'd0;
  localparam logic [1:0] PH_HOLD   = 2'd1;
  localparam logic [1:0] PH_DECAY  = 2'd2;

  // Tone period shown while the note is silent
  localparam logic [15:0] SILENT_PERIOD = 16'd32000;

  // Envelope position ceiling
  localparam logic [11:0] POS_MAX = 12'hFFF;

  // One note table entry
  typedef struct packed {
    logic        last;
    logic [7:0]  length;
    logic [15:0] period;
  } entry_t;

endpackage

>>> hdl/nes_if.sv
// Command channel: tick, start, stop or table write
interface nes_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  entry_index;
  logic [15:0] entry_period;
  logic [7:0]  entry_length;
  logic        entry_last;

  modport source (
    output valid, command, entry_index, entry_period, entry_length, entry_last,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_period, entry_length, entry_last,
    output ready
  );
endinterface

// Result channel: tone and envelope after each command
interface nes_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] tone_period;
  logic [5:0]  pulse_width;
  logic        playing;

  modport source (
    output valid, tone_period, pulse_width, playing,
    input  ready
  );
  modport sink (
    input  valid, tone_period, pulse_width, playing,
    output ready
  );
endinterface

>>> hdl/nes_ram.sv
module nes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/note_envelope_sequencer.sv
// Channel  Dir  Transaction
// cmd      in   command, entry_index, entry_period, entry_length, entry_last
// res      out  tone_period, pulse_width, playing (one per command)
// cfg      in   write-only register port, index 0..7, data 8 bits
//
// One command is taken every cycle while the skid stage is empty; its result
// goes to the output register, or to the skid stage when the output is held.
// The table read address follows the next play index, so the entry for the
// next note load is ready by the following tick. Synchronous reset clears
// control and envelope state; the note table is undefined until written and
// has no clearing pass. A stalled result waits in an output register with a
// skid stage behind it, so one more command is taken before the input stalls.
module note_envelope_sequencer import nes_pkg::*; #(
  parameter int TABLE_DEPTH = NES_TABLE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  nes_cmd_if.sink    cmd,
  nes_res_if.source  res
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_INDEX = ADDR_W'(TABLE_DEPTH - 1);

  // Configuration registers
  logic [5:0] atk_peak, atk_step, hld_floor, hld_step, dcy_step;
  logic [3:0] length_multiplier;
  logic       hold_fixed_enable;
  logic [7:0] hold_fixed_count;

  // Sequencer state
  logic              active, active_next;
  logic [ADDR_W-1:0] play_index, play_index_next;
  logic [11:0]       note_countdown, note_countdown_next;
  logic [15:0]       current_period, current_period_next;
  logic [11:0]       hold_limit, hold_limit_next;
  logic [11:0]       envelope_position, envelope_position_next;
  logic [1:0]        envelope_phase, envelope_phase_next;
  logic [5:0]        width_level, width_level_next;

  // Table access
  logic              accept;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_entry;
  entry_t            rd_entry;
  entry_t            cur_entry;
  logic              fwd_valid;
  entry_t            fwd_entry;

  // Tick arithmetic
  logic [11:0] load_countdown, load_hold;
  logic [11:0] mult_ext;
  logic [ADDR_W-1:0] load_index;
  logic [11:0] pos_base;
  logic [1:0]  phase_base;
  logic [6:0]  attack_sum;
  logic [15:0] tone;

  // Output register and skid stage
  logic        out_valid, skid_valid;
  logic [15:0] out_tone, skid_tone;
  logic [5:0]  out_width, skid_width;
  logic        out_playing, skid_playing;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !skid_valid;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      atk_peak          <= 6'd50;
      atk_step          <= 6'd50;
      hld_floor         <= 6'd8;
      hld_step          <= 6'd15;
      dcy_step          <= 6'd1;
      length_multiplier <= 4'd6;
      hold_fixed_enable <= 1'b1;
      hold_fixed_count  <= 8'd12;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ATTACK_LEVEL:      atk_peak          <= cfg_data[5:0];
        REG_ATTACK_RATE:       atk_step          <= cfg_data[5:0];
        REG_HOLD_LEVEL:        hld_floor         <= cfg_data[5:0];
        REG_HOLD_RATE:         hld_step          <= cfg_data[5:0];
        REG_DECAY_RATE:        dcy_step          <= cfg_data[5:0];
        REG_LENGTH_MULTIPLIER: length_multiplier <= cfg_data[3:0];
        REG_HOLD_FIXED_ENABLE: hold_fixed_enable <= cfg_data[0];
        REG_HOLD_FIXED_COUNT:  hold_fixed_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table write request
  assign wr_en    = accept && (cmd.command == CMD_WRITE) &&
                    (int'(cmd.entry_index) < TABLE_DEPTH);
  assign wr_addr  = ADDR_W'(cmd.entry_index);
  assign wr_entry = '{last: cmd.entry_last, length: cmd.entry_length,
                      period: cmd.entry_period};

  // Read the entry at the upcoming play index every cycle
  nes_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (play_index_next),
    .rdata (rd_entry)
  );

  // Forward a write that hit the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en && (wr_addr == play_index_next);
    end
    fwd_entry <= wr_entry;
  end

  assign cur_entry = fwd_valid ? fwd_entry : rd_entry;

  // Values for loading the next note
  assign mult_ext       = {8'd0, length_multiplier};
  assign load_countdown = {4'd0, cur_entry.length} * mult_ext;
  assign load_hold      = hold_fixed_enable ? {4'd0, hold_fixed_count} :
                          (load_countdown >= mult_ext ? load_countdown - mult_ext : 12'd0);
  assign load_index     = (cur_entry.last || play_index == LAST_INDEX) ?
                          '0 : play_index + 1'b1;

  // Command update
  always_comb begin
    active_next            = active;
    play_index_next        = play_index;
    note_countdown_next    = note_countdown;
    current_period_next    = current_period;
    hold_limit_next        = hold_limit;
    envelope_position_next = envelope_position;
    envelope_phase_next    = envelope_phase;
    width_level_next       = width_level;
    pos_base               = envelope_position;
    phase_base             = envelope_phase;
    attack_sum             = {1'b0, width_level} + {1'b0, atk_step};

    if (accept) begin
      case (cmd.command)
        CMD_TICK: begin
          if (active) begin
            // Count down, or load the next note
            if (note_countdown != 12'd0) begin
              note_countdown_next = note_countdown - 12'd1;
            end else begin
              note_countdown_next = load_countdown;
              current_period_next = cur_entry.period;
              hold_limit_next     = load_hold;
              play_index_next     = load_index;
              pos_base            = 12'd0;
              phase_base          = PH_ATTACK;
            end
            // Advance the envelope position, saturating
            envelope_position_next = (pos_base != POS_MAX) ? pos_base + 12'd1 : pos_base;
            envelope_phase_next    = (envelope_position_next >= hold_limit_next) ?
                                     PH_DECAY : phase_base;
            // Step the width
            case (envelope_phase_next)
              PH_ATTACK: begin
                if (attack_sum >= {1'b0, atk_peak}) begin
                  width_level_next    = atk_peak;
                  envelope_phase_next = PH_HOLD;
                end else begin
                  width_level_next = attack_sum[5:0];
                end
              end
              PH_HOLD: begin
                if ({1'b0, width_level} <= {1'b0, hld_floor} + {1'b0, hld_step}) begin
                  width_level_next = hld_floor;
                end else begin
                  width_level_next = width_level - hld_step;
                end
              end
              default: begin
                if ({1'b0, width_level} <= {1'b0, dcy_step} + 7'd1) begin
                  width_level_next = 6'd1;
                end else begin
                  width_level_next = width_level - dcy_step;
                end
              end
            endcase
          end
        end
        CMD_START: begin
          active_next         = 1'b1;
          play_index_next     = '0;
          note_countdown_next = 12'd0;
        end
        CMD_STOP: begin
          active_next     = 1'b0;
          play_index_next = '0;
        end
        default: ;
      endcase
    end
  end

  assign tone = (active_next && width_level_next != 6'd1) ? current_period_next : SILENT_PERIOD;

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      active            <= 1'b0;
      play_index        <= '0;
      note_countdown    <= 12'd0;
      current_period    <= 16'd0;
      hold_limit        <= 12'd0;
      envelope_position <= 12'd0;
      envelope_phase    <= PH_ATTACK;
      width_level       <= 6'd8;
    end else begin
      active            <= active_next;
      play_index        <= play_index_next;
      note_countdown    <= note_countdown_next;
      current_period    <= current_period_next;
      hold_limit        <= hold_limit_next;
      envelope_position <= envelope_position_next;
      envelope_phase    <= envelope_phase_next;
      width_level       <= width_level_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || res.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (res.ready) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || res.ready) begin
        out_tone    <= tone;
        out_width   <= width_level_next;
        out_playing <= active_next;
      end else begin
        skid_tone    <= tone;
        skid_width   <= width_level_next;
        skid_playing <= active_next;
      end
    end else if (res.ready && skid_valid) begin
      out_tone    <= skid_tone;
      out_width   <= skid_width;
      out_playing <= skid_playing;
    end
  end

  assign res.valid       = out_valid;
  assign res.tone_period = out_tone;
  assign res.pulse_width = out_width;
  assign res.playing     = out_playing;

`ifndef ASSERT_OFF
  // Skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output register empty");

  // Play index stays inside the table
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    int'(play_index) < TABLE_DEPTH)
    else $error("play index beyond table depth");

  // Stop ends playback
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == CMD_STOP) |=> (!active && play_index == '0))
    else $error("stop did not clear playback");

  // A note load restarts the envelope
  a_load_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == CMD_TICK && active && note_countdown == 12'd0)
    |=> (envelope_position == 12'd1))
    else $error("note load did not restart envelope position");
`endif

endmodule
